/* sv/assert_macros.svh */
// Assertion macros for the RTL; included by the top level.
// Active unless SYNTHESIS is defined; empty bodies otherwise.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("never violated");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

/* sv/eact_pkg.sv */
// Package for the encoder angle compensation block: types, codes, constants.
// No dependencies.
package eact_pkg;
  localparam int TableDepthDefault = 64;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 17;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TABLE_WRITE = 2'd1,
    OP_ZERO = 2'd2,
    OP_PRIME = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_ZERO_OFFSET = 3'd0,
    CFG_COMP_ENABLE = 3'd1,
    CFG_COMP_PHASE = 3'd2,
    CFG_COMP_GAIN = 3'd3,
    CFG_DIRECTION = 3'd4,
    CFG_FILTER_ALPHA = 3'd5,
    CFG_DELAY = 3'd6,
    CFG_POLE_PAIRS = 3'd7
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_INTERP, ST_SCALE, ST_ANGLE,
    ST_FILT_MUL, ST_FILT_ADD, ST_EXTRAP, ST_ELEC, ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [15:0] raw_angle;
    logic [9:0] table_index;
    logic [15:0] table_value;
  } in_word_t;

  typedef struct packed {
    logic [15:0] angle;
    logic [15:0] difference;
    logic [31:0] accumulated;
    logic [31:0] filtered_difference;
    logic [15:0] electric_angle;
  } out_word_t;

  // one-hot datapath step strobes
  typedef struct packed {
    logic load;
    logic read;
    logic interp;
    logic scale;
    logic angle;
    logic filt_mul;
    logic filt_add;
    logic extrap;
    logic elec;
  } cmd_t;

  typedef struct packed {
    op_e op;
  } status_t;
endpackage

/* sv/eact_if.sv */
// Valid/ready channel interface carrying one word of type T.
// Depends on nothing.
interface eact_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/eact_ctrl.sv */
// Sequencer: steps the datapath through one item at a time.
// Depends on eact_pkg.
module eact_ctrl (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input logic out_ready_i,
  input eact_pkg::status_t status_i,
  output eact_pkg::cmd_t cmd_o
);
  import eact_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d = (status_i.op == OP_TABLE_WRITE || status_i.op == OP_ZERO) ? ST_IDLE
                                                                             : ST_INTERP;
      end
      ST_INTERP: begin cmd_o.interp = 1'b1; state_d = ST_SCALE; end
      ST_SCALE: begin cmd_o.scale = 1'b1; state_d = ST_ANGLE; end
      ST_ANGLE: begin
        cmd_o.angle = 1'b1;
        state_d = (status_i.op == OP_PRIME) ? ST_IDLE : ST_FILT_MUL;
      end
      ST_FILT_MUL: begin cmd_o.filt_mul = 1'b1; state_d = ST_FILT_ADD; end
      ST_FILT_ADD: begin cmd_o.filt_add = 1'b1; state_d = ST_EXTRAP; end
      ST_EXTRAP: begin cmd_o.extrap = 1'b1; state_d = ST_ELEC; end
      ST_ELEC: begin cmd_o.elec = 1'b1; state_d = ST_OUT; end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

/* sv/eact_dp.sv */
// Datapath: error table, compensation, tracking state, filter, extrapolation.
// Depends on eact_pkg.
module eact_dp #(
  parameter int TableDepth = eact_pkg::TableDepthDefault
) (
  input logic clk_i,
  input logic rst_ni,
  input eact_pkg::cmd_t cmd_i,
  input eact_pkg::in_word_t in_word_i,
  input logic [15:0] zero_offset_i,
  input logic comp_enable_i,
  input logic [15:0] comp_phase_i,
  input logic [14:0] comp_gain_i,
  input logic direction_i,
  input logic [16:0] filter_alpha_i,
  input logic [15:0] delay_i,
  input logic [6:0] pole_pairs_i,
  output eact_pkg::status_t status_o,
  output eact_pkg::out_word_t out_word_o
);
  import eact_pkg::*;
  localparam int IdxW = $clog2(TableDepth);
  localparam int RemW = 16 - IdxW;

  // Table: sweep-free clear through per-entry valid bits.
  logic signed [15:0] tab_mem [TableDepth];
  logic [TableDepth-1:0] tab_vld_q;
  logic signed [15:0] t0_q, t1_q;
  logic t0_v_q, t1_v_q;

  op_e op_q;
  logic [15:0] base_q;
  logic [IdxW-1:0] widx_q;
  logic signed [15:0] wval_q;
  logic [RemW-1:0] rem_q;
  logic signed [17:0] err_q;
  logic signed [15:0] scaled_q;
  logic [15:0] ang_q, diff_q, last_q;
  logic [31:0] acc_q;
  logic signed [31:0] filt_q;
  logic signed [50:0] fprod_q;
  logic signed [48:0] eprod_q;
  logic [31:0] est_q;
  logic [15:0] elec_q;

  assign status_o.op = op_q;

  logic [15:0] a_w;
  logic [IdxW-1:0] i_w, n_w;
  assign a_w = base_q + comp_phase_i;
  assign i_w = a_w[15 -: IdxW];
  assign n_w = i_w + 1'b1;

  logic signed [16:0] tdiff_w;
  logic signed [17+RemW:0] interp_w;
  logic signed [17:0] qt_w;
  assign tdiff_w = 17'(t1_v_q ? t1_q : 16'sd0) - 17'(t0_v_q ? t0_q : 16'sd0);
  assign interp_w = tdiff_w * $signed({1'b0, rem_q});
  // truncate toward zero on the shift
  assign qt_w = 18'((interp_w + ((interp_w < 0) ? ((1 <<< RemW) - 1) : 0)) >>> RemW);

  logic signed [34:0] gprod_w;
  logic signed [34:0] gq_w;
  assign gprod_w = err_q * $signed({1'b0, comp_gain_i});
  assign gq_w = (gprod_w + ((gprod_w < 0) ? 35'sd16383 : 35'sd0)) >>> 14;

  logic [15:0] comp_w, dirang_w, dbits_w;
  assign comp_w = comp_enable_i ? base_q - scaled_q : base_q;
  assign dirang_w = direction_i ? comp_w : 16'(16'd0 - comp_w);
  assign dbits_w = dirang_w - last_q;

  logic signed [33:0] xmy_w;
  assign xmy_w = 34'($signed({diff_q, 16'd0})) - 34'(filt_q);
  logic signed [51:0] fsum_w;
  logic signed [51:0] fq_w;
  assign fq_w = (52'(fprod_q) + ((fprod_q < 0) ? 52'sd65535 : 52'sd0)) >>> 16;
  assign fsum_w = fq_w + 52'(filt_q);
  logic signed [48:0] eq_w;
  assign eq_w = (eprod_q + ((eprod_q < 0) ? 49'sd16777215 : 49'sd0)) >>> 24;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_vld_q <= '0;
      last_q <= '0;
      acc_q <= '0;
      filt_q <= '0;
    end else begin
      if (cmd_i.read && op_q == OP_TABLE_WRITE) tab_vld_q[widx_q] <= 1'b1;
      if (cmd_i.read && op_q == OP_ZERO) begin
        acc_q <= '0;
        filt_q <= '0;
      end
      if (cmd_i.angle) begin
        if (op_q == OP_PRIME) begin
          last_q <= comp_w;
          acc_q <= {16'd0, comp_w};
        end else begin
          last_q <= dirang_w;
          acc_q <= acc_q + 32'($signed(dbits_w));
        end
      end
      if (cmd_i.filt_add) begin
        if (fsum_w > 52'sd2147483647) filt_q <= 32'sh7fffffff;
        else if (fsum_w < -52'sd2147483648) filt_q <= 32'sh80000000;
        else filt_q <= 32'(fsum_w);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_e'(in_word_i.operation);
      widx_q <= in_word_i.table_index[IdxW-1:0];
      wval_q <= in_word_i.table_value;
      base_q <= in_word_i.raw_angle - zero_offset_i;
    end
    if (cmd_i.read) begin
      if (op_q == OP_TABLE_WRITE) tab_mem[widx_q] <= wval_q;
      t0_q <= tab_mem[i_w];
      t1_q <= tab_mem[n_w];
      t0_v_q <= tab_vld_q[i_w];
      t1_v_q <= tab_vld_q[n_w];
      rem_q <= a_w[RemW-1:0];
    end
    if (cmd_i.interp) err_q <= 18'(t0_v_q ? t0_q : 16'sd0) + qt_w;
    if (cmd_i.scale) begin
      if (gq_w > 35'sd32767) scaled_q <= 16'sh7fff;
      else if (gq_w < -35'sd32768) scaled_q <= 16'sh8000;
      else scaled_q <= 16'(gq_w);
    end
    if (cmd_i.angle) begin
      ang_q <= dirang_w;
      diff_q <= dbits_w;
    end
    if (cmd_i.filt_mul) fprod_q <= xmy_w * $signed({1'b0, filter_alpha_i});
    if (cmd_i.extrap) eprod_q <= filt_q * $signed({1'b0, delay_i});
    if (cmd_i.elec) est_q <= acc_q + 32'(eq_w);
    if (cmd_i.elec) elec_q <= '0;
  end

  // one small multiply after the estimate register
  logic [15:0] emul_w;
  assign emul_w = 16'(est_q[15:0] * pole_pairs_i);

  assign out_word_o.angle = ang_q;
  assign out_word_o.difference = diff_q;
  assign out_word_o.accumulated = acc_q;
  assign out_word_o.filtered_difference = filt_q;
  assign out_word_o.electric_angle = emul_w | elec_q;
endmodule

/* sv/encoder_angle_compensate_track_unit.sv */
// Top level of the encoder angle compensation and tracking block.
// Depends on eact_pkg, eact_if, eact_ctrl, eact_dp and assert_macros.svh.
//
// Usage:
//  - in_ch carries one word per operation: sample, table write, zero state
//    or prime. Only a sample produces a word on out_ch.
//  - A sample passes through the fixed step sequence of the controller:
//    table read, interpolation, gain, angle, filter multiply and add,
//    extrapolation and electric angle, then out_valid. A table write or zero
//    state frees the input after the table read, a prime after the angle step.
//  - One word is in flight at a time; the input is ready only when idle.
//  - When the receiver stalls, the result holds on out_ch and no new word
//    is taken until it leaves.
//  - Reset clears the controller, the tracking state, the filter and the
//    table valid bits, so every table entry reads zero until written; the
//    configuration returns to its reset values. No clearing pass is needed.
//  - Configuration: cfg_we_i, cfg_idx_i, cfg_data_i, written while idle;
//    indexes follow the register list, widths are the low data bits.
`include "assert_macros.svh"
module encoder_angle_compensate_track_unit #(
  parameter int TableDepth = eact_pkg::TableDepthDefault
) (
  input logic clk_i,
  input logic rst_ni,
  input logic cfg_we_i,
  input logic [eact_pkg::CfgIdxW-1:0] cfg_idx_i,
  input logic [eact_pkg::CfgDataW-1:0] cfg_data_i,
  eact_if.sink in_ch,
  eact_if.source out_ch
);
  import eact_pkg::*;

  logic [15:0] zero_offset_q, comp_phase_q, delay_q;
  logic comp_enable_q, direction_q;
  logic [14:0] comp_gain_q;
  logic [16:0] filter_alpha_q;
  logic [6:0] pole_pairs_q;

  // register writes; each keeps its own low bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_offset_q <= '0;
      comp_enable_q <= 1'b0;
      comp_phase_q <= '0;
      comp_gain_q <= 15'd16384;
      direction_q <= 1'b1;
      filter_alpha_q <= 17'd65536;
      delay_q <= '0;
      pole_pairs_q <= 7'd1;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_ZERO_OFFSET: zero_offset_q <= cfg_data_i[15:0];
        CFG_COMP_ENABLE: comp_enable_q <= cfg_data_i[0];
        CFG_COMP_PHASE: comp_phase_q <= cfg_data_i[15:0];
        CFG_COMP_GAIN: comp_gain_q <= cfg_data_i[14:0];
        CFG_DIRECTION: direction_q <= cfg_data_i[0];
        CFG_FILTER_ALPHA: filter_alpha_q <= cfg_data_i;
        CFG_DELAY: delay_q <= cfg_data_i[15:0];
        CFG_POLE_PAIRS: pole_pairs_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  cmd_t cmd;
  status_t status;

  eact_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .status_i(status), .cmd_o(cmd)
  );

  eact_dp #(.TableDepth(TableDepth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_word_i(in_ch.data),
    .zero_offset_i(zero_offset_q), .comp_enable_i(comp_enable_q),
    .comp_phase_i(comp_phase_q), .comp_gain_i(comp_gain_q),
    .direction_i(direction_q), .filter_alpha_i(filter_alpha_q),
    .delay_i(delay_q), .pole_pairs_i(pole_pairs_q),
    .status_o(status), .out_word_o(out_ch.data)
  );

  // never ready for input while a result is pending
  `ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, in_ch.ready && out_ch.valid)
  // a new word always starts the table read step next
  `ASSERT_IMPL(a_load_read, clk_i, rst_ni, (in_ch.valid && in_ch.ready) |=> cmd.read)
  // a delivered result returns the controller to idle
  `ASSERT_IMPL(a_out_idle, clk_i, rst_ni, (out_ch.valid && out_ch.ready) |=> in_ch.ready)
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for encoder_angle_compensate_track_unit.
// Depends on eact_pkg, eact_if and the top level; predicts each sample word and checks every output field.
module tb;
  import eact_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  eact_if #(.T(in_word_t)) in_ch ();
  eact_if #(.T(out_word_t)) out_ch ();

  encoder_angle_compensate_track_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Predictor copy of configuration and tracking state.
  logic [15:0] zero_cnt;
  logic comp_en;
  logic [15:0] comp_phase;
  logic [14:0] comp_gain;
  logic dir_keep;
  logic [16:0] alpha;
  logic [15:0] delay_q88;
  logic [6:0] pole_cnt;
  logic signed [15:0] err_tab [64];
  logic [15:0] prev_angle;
  logic [31:0] turns;
  logic signed [31:0] filt_diff;

  in_word_t pending_words[$];
  out_word_t expected_words[$];
  int fail_cnt;
  int idle_cycles;
  bit in_taken;
  bit no_gaps;
  int send_gap;
  int recv_gap;
  logic [15:0] walk_raw;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Gap length: mostly none or short, a few long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (no_gaps || p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [15:0] compensated(logic [15:0] raw);
    logic [15:0] base;
    logic [15:0] a;
    logic [5:0] i;
    logic [5:0] n;
    longint r;
    longint e;
    longint scaled;
    base = raw - zero_cnt;
    if (!comp_en) return base;
    a = base + comp_phase;
    i = a[15:10];
    n = i + 6'd1;
    r = longint'(a[9:0]);
    e = longint'(err_tab[i]) + (longint'(err_tab[n]) - longint'(err_tab[i])) * r / 1024;
    scaled = e * longint'(comp_gain) / 16384;
    if (scaled > 32767) scaled = 32767;
    if (scaled < -32768) scaled = -32768;
    return base - scaled[15:0];
  endfunction

  // Apply one accepted word to the predictor; push a result for samples.
  task automatic track_word(in_word_t w);
    out_word_t o;
    logic [15:0] ang;
    logic [15:0] dbits;
    logic [31:0] est;
    logic [31:0] prod;
    longint diff;
    longint y;
    longint ext;
    case (op_e'(w.operation))
      OP_TABLE_WRITE: err_tab[w.table_index[5:0]] = w.table_value;
      OP_ZERO: begin
        turns = '0;
        filt_diff = '0;
      end
      OP_PRIME: begin
        prev_angle = compensated(w.raw_angle);
        turns = {16'd0, prev_angle};
      end
      default: begin
        ang = compensated(w.raw_angle);
        if (!dir_keep) ang = -ang;
        dbits = ang - prev_angle;
        diff = longint'($signed(dbits));
        prev_angle = ang;
        turns = turns + diff[31:0];
        y = longint'(filt_diff);
        y = y + longint'(alpha) * (diff * 65536 - y) / 65536;
        if (y > 64'sd2147483647) y = 64'sd2147483647;
        if (y < -64'sd2147483648) y = -64'sd2147483648;
        filt_diff = y[31:0];
        ext = longint'(filt_diff) * longint'(delay_q88) / 16777216;
        est = turns + ext[31:0];
        prod = est * {25'd0, pole_cnt};
        o.angle = ang;
        o.difference = dbits;
        o.accumulated = turns;
        o.filtered_difference = filt_diff;
        o.electric_angle = prod[15:0];
        expected_words.push_back(o);
      end
    endcase
  endtask

  // Monitor: sample both channels at the rising edge.
  always @(posedge clk_i) begin
    out_word_t exp_w;
    out_word_t got;
    in_taken <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        track_word(in_ch.data);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          fail_cnt++;
        end else begin
          exp_w = expected_words.pop_front();
          if (got.angle !== exp_w.angle) begin
            $display("%0t: angle exp %h got %h", $time, exp_w.angle, got.angle);
            fail_cnt++;
          end
          if (got.difference !== exp_w.difference) begin
            $display("%0t: difference exp %h got %h", $time, exp_w.difference, got.difference);
            fail_cnt++;
          end
          if (got.accumulated !== exp_w.accumulated) begin
            $display("%0t: accumulated exp %h got %h", $time, exp_w.accumulated,
                     got.accumulated);
            fail_cnt++;
          end
          if (got.filtered_difference !== exp_w.filtered_difference) begin
            $display("%0t: filtered_difference exp %h got %h", $time,
                     exp_w.filtered_difference, got.filtered_difference);
            fail_cnt++;
          end
          if (got.electric_angle !== exp_w.electric_angle) begin
            $display("%0t: electric_angle exp %h got %h", $time, exp_w.electric_angle,
                     got.electric_angle);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Driver: hold the word until taken, then insert a gap, then advance the queue.
  always @(negedge clk_i) begin
    logic nxt_valid;
    in_word_t nxt_data;
    logic nxt_ready;
    nxt_valid = in_ch.valid;
    nxt_data = in_ch.data;
    if (rst_ni) begin
      if (!in_ch.valid || in_taken) begin
        nxt_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() > 0) begin
          nxt_data = pending_words.pop_front();
          nxt_valid = 1'b1;
          send_gap = pick_gap();
        end
      end
      // Stall the receiver at random.
      if (recv_gap > 0) begin
        recv_gap--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
        if ($urandom_range(3) == 0) recv_gap = pick_gap();
      end
      out_ch.ready <= nxt_ready;
    end
    in_ch.valid <= nxt_valid;
    in_ch.data <= nxt_data;
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_cfg(cfg_e idx, logic [16:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_ZERO_OFFSET: zero_cnt = val[15:0];
      CFG_COMP_ENABLE: comp_en = val[0];
      CFG_COMP_PHASE: comp_phase = val[15:0];
      CFG_COMP_GAIN: comp_gain = val[14:0];
      CFG_DIRECTION: dir_keep = val[0];
      CFG_FILTER_ALPHA: alpha = val;
      CFG_DELAY: delay_q88 = val[15:0];
      default: pole_cnt = val[6:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] zo, logic en, logic [15:0] ph, logic [14:0] g,
                           logic d, logic [16:0] al, logic [15:0] dl, logic [6:0] pp);
    write_cfg(CFG_ZERO_OFFSET, {1'b0, zo});
    write_cfg(CFG_COMP_ENABLE, {16'd0, en});
    write_cfg(CFG_COMP_PHASE, {1'b0, ph});
    write_cfg(CFG_COMP_GAIN, {2'd0, g});
    write_cfg(CFG_DIRECTION, {16'd0, d});
    write_cfg(CFG_FILTER_ALPHA, al);
    write_cfg(CFG_DELAY, {1'b0, dl});
    write_cfg(CFG_POLE_PAIRS, {10'd0, pp});
  endtask

  function automatic in_word_t make_word(op_e op, logic [15:0] raw, logic [5:0] idx,
                                         logic [15:0] val);
    in_word_t w;
    w.operation = op;
    w.raw_angle = raw;
    w.table_index = {4'd0, idx};
    w.table_value = val;
    return w;
  endfunction

  // Hold until every queued word has gone and every result arrived, then let the
  // pipeline drain before touching the registers.
  task automatic wait_quiet();
    wait (pending_words.size() == 0 && !in_ch.valid && expected_words.size() == 0);
    repeat (15) @(posedge clk_i);
  endtask

  // Mostly tracking-style samples with a walking raw angle; table writes and the
  // occasional prime or zero mixed in.
  task automatic random_phase(int count);
    int p;
    for (int k = 0; k < count; k++) begin
      p = $urandom_range(99);
      if (p < 8) begin
        pending_words.push_back(make_word(OP_TABLE_WRITE, 16'($urandom()), 6'($urandom()),
                                          16'($urandom())));
      end else if (p < 11) begin
        pending_words.push_back(make_word(OP_ZERO, 16'($urandom()), 6'($urandom()),
                                          16'($urandom())));
      end else if (p < 14) begin
        walk_raw = 16'($urandom());
        pending_words.push_back(make_word(OP_PRIME, walk_raw, 6'($urandom()),
                                          16'($urandom())));
      end else begin
        if ($urandom_range(9) < 7) walk_raw = walk_raw + 16'($urandom_range(4000)) - 16'd2000;
        else walk_raw = 16'($urandom());
        pending_words.push_back(make_word(OP_SAMPLE, walk_raw, 6'($urandom()),
                                          16'($urandom())));
      end
    end
  endtask

  initial begin
    fail_cnt = 0;
    idle_cycles = 0;
    send_gap = 0;
    recv_gap = 0;
    no_gaps = 1'b0;
    walk_raw = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    zero_cnt = '0;
    comp_en = 1'b0;
    comp_phase = '0;
    comp_gain = 15'd16384;
    dir_keep = 1'b1;
    alpha = 17'd65536;
    delay_q88 = '0;
    pole_cnt = 7'd1;
    for (int k = 0; k < 64; k++) err_tab[k] = '0;
    prev_angle = '0;
    turns = '0;
    filt_diff = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset settings, field extremes, every operation.
    pending_words.push_back(make_word(OP_SAMPLE, 16'h0000, 6'd0, 16'h0000));
    pending_words.push_back(make_word(OP_SAMPLE, 16'hFFFF, 6'd63, 16'hFFFF));
    pending_words.push_back(make_word(OP_SAMPLE, 16'h8000, 6'd0, 16'h0000));
    pending_words.push_back(make_word(OP_SAMPLE, 16'h0001, 6'd0, 16'h0000));
    pending_words.push_back(make_word(OP_TABLE_WRITE, 16'h0000, 6'd0, 16'h7FFF));
    pending_words.push_back(make_word(OP_TABLE_WRITE, 16'hFFFF, 6'd1, 16'h8000));
    pending_words.push_back(make_word(OP_TABLE_WRITE, 16'h0000, 6'd63, 16'h8000));
    pending_words.push_back(make_word(OP_PRIME, 16'h1234, 6'd0, 16'h0000));
    pending_words.push_back(make_word(OP_SAMPLE, 16'h9234, 6'd0, 16'h0000));
    pending_words.push_back(make_word(OP_ZERO, 16'hFFFF, 6'd63, 16'hFFFF));
    pending_words.push_back(make_word(OP_SAMPLE, 16'h1234, 6'd0, 16'h0000));
    wait_quiet();

    // Upper extremes, compensation on across the table wrap, overshooting filter.
    write_all(16'hFFFF, 1'b1, 16'h8000, 15'h7FFF, 1'b0, 17'h1FFFF, 16'hFFFF, 7'd64);
    pending_words.push_back(make_word(OP_SAMPLE, 16'h0000, 6'd0, 16'h0000));
    pending_words.push_back(make_word(OP_SAMPLE, 16'hFFFF, 6'd0, 16'h0000));
    pending_words.push_back(make_word(OP_SAMPLE, 16'h7C00, 6'd0, 16'h0000));
    pending_words.push_back(make_word(OP_SAMPLE, 16'h7FFF, 6'd0, 16'h0000));
    pending_words.push_back(make_word(OP_PRIME, 16'h4000, 6'd0, 16'h0000));
    random_phase(200);
    wait_quiet();

    // Lower extremes: no gain, frozen filter, no delay, zero pole pairs.
    write_all(16'h0000, 1'b1, 16'h7FFF, 15'd0, 1'b1, 17'd0, 16'd0, 7'd0);
    no_gaps = 1'b1;
    random_phase(150);
    wait_quiet();
    no_gaps = 1'b0;

    write_all(16'h0000, 1'b1, 16'h0000, 15'd16384, 1'b1, 17'd65536, 16'h0100, 7'd127);
    random_phase(150);
    wait_quiet();

    for (int ph = 0; ph < 5; ph++) begin
      write_all(16'($urandom()), $urandom_range(3) != 0, 16'($urandom()), 15'($urandom()),
                1'($urandom()), 17'($urandom_range(131071)), 16'($urandom()),
                7'($urandom_range(64, 1)));
      no_gaps = (ph == 2);
      random_phase(140);
      wait_quiet();
    end

    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
